>>> rtl/dci_pkg.sv
// Package for the disc collision impulse block: word types and widths.
// No dependencies; used by the top level and its checker.
package dci_pkg;

    localparam int VelW  = 20;
    localparam int RadW  = 16;
    localparam int KW    = 17;
    // quotient bits: |dot*d/dist2| stays below 2^22
    localparam int QW    = 23;
    // divider numerator and denominator widths while discs overlap
    localparam int NumW  = 57;
    localparam int DenW  = 34;
    localparam int NumStages = 4 + QW + 2;

    localparam logic [KW-1:0] KOne = KW'(65536);

    typedef struct packed {
        logic signed [VelW-1:0] first_pos_x;
        logic signed [VelW-1:0] first_pos_y;
        logic signed [VelW-1:0] second_pos_x;
        logic signed [VelW-1:0] second_pos_y;
        logic signed [VelW-1:0] first_vel_x;
        logic signed [VelW-1:0] first_vel_y;
        logic signed [VelW-1:0] second_vel_x;
        logic signed [VelW-1:0] second_vel_y;
        logic        [RadW-1:0] first_radius;
        logic        [RadW-1:0] second_radius;
    } t_in_item;

    typedef struct packed {
        logic signed [VelW-1:0] new_first_vel_x;
        logic signed [VelW-1:0] new_first_vel_y;
        logic signed [VelW-1:0] new_second_vel_x;
        logic signed [VelW-1:0] new_second_vel_y;
        logic                   collided;
    } t_out_item;

    // velocities and flags carried down the pipeline
    typedef struct packed {
        logic signed [VelW-1:0] v1x;
        logic signed [VelW-1:0] v1y;
        logic signed [VelW-1:0] v2x;
        logic signed [VelW-1:0] v2y;
        logic                   hit;
        logic                   sgn_x;
        logic                   sgn_y;
        logic        [DenW-1:0] den;
    } t_ctx;

endpackage

>>> rtl/disc_collision_impulse_top.sv
// Throughput: one word per cycle while the output is not stalled; the two
// 23-stage restoring dividers (one quotient bit per stage) set the depth,
// not the rate. The whole pipeline advances whenever its last stage is empty
// or taken.
// Reset (synchronous, active low) empties every stage and sets the
// restitution register to one; the config port is always ready.
module disc_collision_impulse_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  dci_pkg::t_in_item      i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output dci_pkg::t_out_item     o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [dci_pkg::KW-1:0] i_cfg_data
);
    import dci_pkg::*;

    logic              en;
    logic [NumStages-1:0] r_vld;
    logic [KW-1:0]     r_k;

    // advance when the output stage is free or being taken
    assign en          = ~r_vld[NumStages-1] | i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[NumStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_k   <= KOne;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NumStages-2:0], i_in_valid};
            end
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
        end
    end

    // stage 1: differences and radius sum
    t_ctx               r1_ctx;
    logic signed [20:0] r1_dx, r1_dy, r1_dvx, r1_dvy;
    logic        [16:0] r1_rsum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ctx.v1x   <= i_in_data.first_vel_x;
            r1_ctx.v1y   <= i_in_data.first_vel_y;
            r1_ctx.v2x   <= i_in_data.second_vel_x;
            r1_ctx.v2y   <= i_in_data.second_vel_y;
            r1_ctx.hit   <= 1'b0;
            r1_ctx.sgn_x <= 1'b0;
            r1_ctx.sgn_y <= 1'b0;
            r1_ctx.den   <= '0;
            r1_dx   <= 21'(i_in_data.second_pos_x) - 21'(i_in_data.first_pos_x);
            r1_dy   <= 21'(i_in_data.second_pos_y) - 21'(i_in_data.first_pos_y);
            r1_dvx  <= 21'(i_in_data.first_vel_x) - 21'(i_in_data.second_vel_x);
            r1_dvy  <= 21'(i_in_data.first_vel_y) - 21'(i_in_data.second_vel_y);
            r1_rsum <= 17'(i_in_data.first_radius) + 17'(i_in_data.second_radius);
        end
    end

    // stage 2: squares and dot-product terms; overlap bounds |d| below 2^17
    t_ctx               r2_ctx;
    logic        [40:0] r2_dx2, r2_dy2;
    logic        [33:0] r2_rsum2;
    logic signed [38:0] r2_px, r2_py;
    logic signed [17:0] r2_dx, r2_dy;
    logic signed [20:0] r2_dvx;
    logic signed [41:0] n_sqx, n_sqy;
    logic signed [38:0] n_px, n_py;

    always_comb begin
        n_sqx = r1_dx * r1_dx;
        n_sqy = r1_dy * r1_dy;
        n_px  = r1_dvx * $signed(r1_dx[17:0]);
        n_py  = r1_dvy * $signed(r1_dy[17:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ctx   <= r1_ctx;
            r2_dx2   <= n_sqx[40:0];
            r2_dy2   <= n_sqy[40:0];
            r2_rsum2 <= r1_rsum * r1_rsum;
            r2_px    <= n_px;
            r2_py    <= n_py;
            r2_dx    <= r1_dx[17:0];
            r2_dy    <= r1_dy[17:0];
            r2_dvx   <= r1_dvx;
        end
    end

    // stage 3: overlap test, dot product, coincident-centre fallback
    t_ctx               r3_ctx;
    logic signed [39:0] r3_dot;
    logic signed [17:0] r3_dx, r3_dy;
    logic        [41:0] n_dist2;
    logic               n_hit;
    t_ctx               n3_ctx;

    always_comb begin
        n_dist2    = 42'(r2_dx2) + 42'(r2_dy2);
        n_hit      = n_dist2 < 42'(r2_rsum2);
        n3_ctx     = r2_ctx;
        n3_ctx.hit = n_hit;
        n3_ctx.den = (n_dist2 == '0) ? DenW'(1) : n_dist2[DenW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ctx <= n3_ctx;
            if (n_dist2 == '0) begin
                r3_dot <= 40'(r2_dvx);
                r3_dx  <= 18'sd1;
                r3_dy  <= '0;
            end else begin
                r3_dot <= 40'(r2_px) + 40'(r2_py);
                r3_dx  <= r2_dx;
                r3_dy  <= r2_dy;
            end
        end
    end

    // stage 4: numerators dot*d, magnitude plus half divisor for rounding
    t_ctx             r_ctx  [QW+1];
    logic [NumW-1:0]  r_remx [QW+1];
    logic [NumW-1:0]  r_remy [QW+1];
    logic [QW-1:0]    r_qx   [QW+1];
    logic [QW-1:0]    r_qy   [QW+1];
    logic signed [57:0] n_prx, n_pry;
    logic        [57:0] n_magx, n_magy;
    t_ctx               n4_ctx;

    always_comb begin
        n_prx  = r3_dot * r3_dx;
        n_pry  = r3_dot * r3_dy;
        n_magx = n_prx[57] ? 58'(-n_prx) : 58'(n_prx);
        n_magy = n_pry[57] ? 58'(-n_pry) : 58'(n_pry);
        n4_ctx       = r3_ctx;
        n4_ctx.sgn_x = n_prx[57];
        n4_ctx.sgn_y = n_pry[57];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0]  <= n4_ctx;
            r_remx[0] <= n_magx[NumW-1:0] + NumW'(r3_ctx.den >> 1);
            r_remy[0] <= n_magy[NumW-1:0] + NumW'(r3_ctx.den >> 1);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    // divider stages: one quotient bit each, most significant first
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [NumW-1:0] n_sd, n_remx, n_remy;
        logic [QW-1:0]   n_qx, n_qy;
        assign n_sd = NumW'(r_ctx[j].den) << (QW - 1 - j);

        always_comb begin
            n_qx = r_qx[j];
            n_qy = r_qy[j];
            if (r_remx[j] >= n_sd) begin
                n_remx         = r_remx[j] - n_sd;
                n_qx[QW-1-j]   = 1'b1;
            end else begin
                n_remx         = r_remx[j];
            end
            if (r_remy[j] >= n_sd) begin
                n_remy         = r_remy[j] - n_sd;
                n_qy[QW-1-j]   = 1'b1;
            end else begin
                n_remy         = r_remy[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctx[j+1]  <= r_ctx[j];
                r_qx[j+1]   <= n_qx;
                r_qy[j+1]   <= n_qy;
                r_remx[j+1] <= n_remx;
                r_remy[j+1] <= n_remy;
            end
        end
    end

    // scale by restitution, clamped to one
    t_ctx               r5_ctx;
    logic [QW+KW-1:0]   r5_ex, r5_ey;
    logic [KW-1:0]      n_k;

    assign n_k = (r_k > KOne) ? KOne : r_k;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ctx <= r_ctx[QW];
            r5_ex  <= r_qx[QW] * n_k;
            r5_ey  <= r_qy[QW] * n_k;
        end
    end

    // round, apply sign, transfer impulse and saturate
    logic [QW+KW:0]     n_rx, n_ry;
    logic signed [24:0] n_ex, n_ey;
    logic signed [25:0] n_1x, n_1y, n_2x, n_2y;
    t_out_item          r_out;

    function automatic logic signed [VelW-1:0] sat(input logic signed [25:0] v);
        logic signed [25:0] hi, lo;
        hi = 26'sd524287;
        lo = -26'sd524288;
        if (v > hi) begin
            sat = VelW'(hi);
        end else if (v < lo) begin
            sat = VelW'(lo);
        end else begin
            sat = v[VelW-1:0];
        end
    endfunction

    always_comb begin
        n_rx = (QW+KW+1)'(r5_ex) + (QW+KW+1)'(32768);
        n_ry = (QW+KW+1)'(r5_ey) + (QW+KW+1)'(32768);
        n_ex = r5_ctx.sgn_x ? -$signed({1'b0, n_rx[39:16]}) : $signed({1'b0, n_rx[39:16]});
        n_ey = r5_ctx.sgn_y ? -$signed({1'b0, n_ry[39:16]}) : $signed({1'b0, n_ry[39:16]});
        if (r5_ctx.hit) begin
            n_1x = 26'(r5_ctx.v1x) - 26'(n_ex);
            n_1y = 26'(r5_ctx.v1y) - 26'(n_ey);
            n_2x = 26'(r5_ctx.v2x) + 26'(n_ex);
            n_2y = 26'(r5_ctx.v2y) + 26'(n_ey);
        end else begin
            n_1x = 26'(r5_ctx.v1x);
            n_1y = 26'(r5_ctx.v1y);
            n_2x = 26'(r5_ctx.v2x);
            n_2y = 26'(r5_ctx.v2y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.new_first_vel_x  <= sat(n_1x);
            r_out.new_first_vel_y  <= sat(n_1y);
            r_out.new_second_vel_x <= sat(n_2x);
            r_out.new_second_vel_y <= sat(n_2y);
            r_out.collided         <= r5_ctx.hit;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/dci_checker.sv
// Port-level checker for the disc collision impulse block, with its bind.
// Depends on dci_pkg and disc_collision_impulse_top.
module dci_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dci_pkg::t_out_item o_out_data,
    input logic               o_cfg_ready
);
    import dci_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // an empty output stage never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with output empty");

    // a stalled output stage freezes the input
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // reset drains the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_cfg_ready)
        else $error("result word present after reset");

endmodule

bind disc_collision_impulse_top dci_checker u_dci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

>>> tb/sv/tb_dci_checker.sv
// Checker for the disc collision impulse block: watches the input, output and
// config channels, predicts each result word and compares it field by field.
// Depends on dci_pkg for the word types and widths.
module tb_dci_checker
    import dci_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [KW-1:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_hit_count
);

    logic [KW-1:0] restitution;
    t_out_item     expected_q[$];

    // round to nearest, ties away from zero; den > 0
    function automatic longint div_round(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [VelW-1:0] clamp_vel(longint v);
        if (v > 524287) return VelW'(524287);
        if (v < -524288) return VelW'(-524288);
        return VelW'(v);
    endfunction

    // compute the post-collision velocities for one disc pair
    function automatic t_out_item predict_impulse(t_in_item w, logic [KW-1:0] kreg);
        t_out_item r;
        longint dx, dy, v1x, v1y, v2x, v2y, dot, qx, qy, ex, ey, k;
        longint unsigned dist2, rsum;
        v1x = w.first_vel_x;  v1y = w.first_vel_y;
        v2x = w.second_vel_x; v2y = w.second_vel_y;
        dx = longint'(w.second_pos_x) - longint'(w.first_pos_x);
        dy = longint'(w.second_pos_y) - longint'(w.first_pos_y);
        dist2 = dx * dx + dy * dy;
        rsum = longint'(w.first_radius) + longint'(w.second_radius);
        r.collided = 1'b0;
        if (dist2 < rsum * rsum) begin
            k = (kreg > KOne) ? 65536 : longint'(kreg);
            if (dist2 == 0) begin
                dx = 1; dy = 0; dist2 = 1;
            end
            dot = (v1x - v2x) * dx + (v1y - v2y) * dy;
            qx = div_round(dot * dx, dist2);
            qy = div_round(dot * dy, dist2);
            ex = div_round(qx * k, 65536);
            ey = div_round(qy * k, 65536);
            v1x -= ex; v1y -= ey; v2x += ex; v2y += ey;
            r.collided = 1'b1;
        end
        r.new_first_vel_x  = clamp_vel(v1x);
        r.new_first_vel_y  = clamp_vel(v1y);
        r.new_second_vel_x = clamp_vel(v2x);
        r.new_second_vel_y = clamp_vel(v2y);
        return r;
    endfunction

    assign o_pending = expected_q.size();

    // track config, queue predictions, compare result words
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (!i_rst_n) begin
            restitution  <= KOne;
            o_fail_count <= 0;
            o_hit_count  <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) restitution <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_q = {expected_q, predict_impulse(i_in_data, restitution)};
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no prediction waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (exp_w.collided) o_hit_count <= o_hit_count + 1;
                    if (exp_w != i_out_data) begin
                        o_fail_count <= o_fail_count + 1;
                        if (exp_w.new_first_vel_x != i_out_data.new_first_vel_x)
                            $error("new_first_vel_x: expected %0d, got %0d",
                                   exp_w.new_first_vel_x, i_out_data.new_first_vel_x);
                        if (exp_w.new_first_vel_y != i_out_data.new_first_vel_y)
                            $error("new_first_vel_y: expected %0d, got %0d",
                                   exp_w.new_first_vel_y, i_out_data.new_first_vel_y);
                        if (exp_w.new_second_vel_x != i_out_data.new_second_vel_x)
                            $error("new_second_vel_x: expected %0d, got %0d",
                                   exp_w.new_second_vel_x, i_out_data.new_second_vel_x);
                        if (exp_w.new_second_vel_y != i_out_data.new_second_vel_y)
                            $error("new_second_vel_y: expected %0d, got %0d",
                                   exp_w.new_second_vel_y, i_out_data.new_second_vel_y);
                        if (exp_w.collided != i_out_data.collided)
                            $error("collided: expected %0b, got %0b",
                                   exp_w.collided, i_out_data.collided);
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for disc_collision_impulse_top: makes disc-pair stimulus with
// bursty input and stalling output, writes restitution between phases.
// Depends on dci_pkg, the block and tb_dci_checker.
module tb_top;
    import dci_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    t_in_item      in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    t_out_item     out_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [KW-1:0] cfg_data = '0;
    int            fail_count, pending, hit_count;
    int            idle_cycles = 0;
    int            sent_count = 0;
    bit            stall_enable = 1'b0;

    always #5 clk = ~clk;

    disc_collision_impulse_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    tb_dci_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_hit_count(hit_count)
    );

    // stall the receiver on its own pattern: calm stretches and stall bursts
    always @(negedge clk) begin
        if (!stall_enable) out_ready <= 1'b1;
        else if ($urandom_range(0, 63) == 0) out_ready <= 1'b1;
        else if ($urandom_range(0, 3) == 0) out_ready <= ~out_ready;
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // present one word and hold it until taken
    task automatic send_pair(t_in_item w);
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        in_data  <= '0;
    endtask

    task automatic drain();
        drop_valid();
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_restitution(logic [KW-1:0] k);
        cfg_data  <= k;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VelW-1:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return VelW'(524287);
            1: return VelW'(-524288);
            2: return VelW'($urandom);
            default: return VelW'(int'($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    // mostly overlapping pairs with random geometry, some separated or odd
    function automatic t_in_item rand_pair();
        t_in_item w;
        int span;
        w.first_vel_x = rand_vel();  w.first_vel_y = rand_vel();
        w.second_vel_x = rand_vel(); w.second_vel_y = rand_vel();
        case ($urandom_range(0, 9))
            0: begin
                w.first_pos_x = VelW'($urandom); w.first_pos_y = VelW'($urandom);
                w.second_pos_x = VelW'($urandom); w.second_pos_y = VelW'($urandom);
                w.first_radius = RadW'($urandom); w.second_radius = RadW'($urandom);
            end
            1: begin
                w.first_pos_x = VelW'($urandom); w.first_pos_y = VelW'($urandom);
                w.second_pos_x = w.first_pos_x; w.second_pos_y = w.first_pos_y;
                w.first_radius = RadW'($urandom_range(0, 3));
                w.second_radius = RadW'($urandom_range(0, 3));
            end
            default: begin
                span = $urandom_range(0, 3) == 0 ? 131071 : 8000;
                w.first_pos_x = VelW'(int'($urandom_range(0, 2*span)) - span);
                w.first_pos_y = VelW'(int'($urandom_range(0, 2*span)) - span);
                w.second_pos_x = VelW'(int'($urandom_range(0, 2*span)) - span);
                w.second_pos_y = VelW'(int'($urandom_range(0, 2*span)) - span);
                w.first_radius = RadW'($urandom_range(span / 2, 65535));
                w.second_radius = RadW'($urandom_range(span / 2, 65535));
            end
        endcase
        return w;
    endfunction

    // directed pairs: extremes, coincident centres, touching, zero radii
    task automatic directed_phase();
        t_in_item w;
        w = '0;
        send_pair(w);
        w.first_radius = 16'd256; w.first_vel_x = 20'sd1000;
        send_pair(w);
        w.second_pos_x = 20'sd256;
        send_pair(w);
        w.second_pos_x = 20'sd255;
        send_pair(w);
        w = '0;
        w.first_pos_x = VelW'(-524288); w.first_pos_y = VelW'(-524288);
        w.second_pos_x = VelW'(524287); w.second_pos_y = VelW'(524287);
        w.first_radius = 16'hFFFF; w.second_radius = 16'hFFFF;
        w.first_vel_x = VelW'(524287); w.first_vel_y = VelW'(-524288);
        w.second_vel_x = VelW'(-524288); w.second_vel_y = VelW'(524287);
        send_pair(w);
        w.first_pos_x = '0; w.first_pos_y = '0; w.second_pos_x = 20'sd3;
        w.second_pos_y = 20'sd4;
        send_pair(w);
        w.second_pos_x = '0; w.second_pos_y = '0;
        send_pair(w);
        w.first_vel_x = VelW'(-524288); w.second_vel_x = VelW'(524287);
        send_pair(w);
        w = '1;
        send_pair(w);
        w.second_pos_x = '0; w.second_pos_y = 20'sd100;
        w.first_vel_x = 20'sd5; w.second_vel_y = 20'sd77;
        send_pair(w);
        repeat (8) send_pair(rand_pair());
    endtask

    // one random phase: bursts of pairs with random gaps, at most one full-drain pause
    task automatic random_phase(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0) begin
                send_pair(rand_pair());
                burst--; left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            if (left == count / 2) begin
                drop_valid();
                while (pending != 0) @(negedge clk);
            end
        end
    endtask

    initial begin
        logic [KW-1:0] scales[6];
        scales = '{KW'(65536), KW'(0), KW'(131071), KW'(32768), KW'(65535), KW'(1)};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_phase();
        drain();
        stall_enable = 1'b1;
        for (int p = 0; p < 6; p++) begin
            write_restitution(scales[p]);
            if (p == 1) directed_phase();
            random_phase(p == 5 ? 280 : 230);
            drain();
            write_restitution(KW'($urandom));
            random_phase(30);
            drain();
        end
        $display("covered %0d disc pairs over %0d restitution settings, %0d collisions",
                 sent_count, 12, hit_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
